FILE: design/ddio_pkg.sv
// Package for the differential-drive odometry core.
// Holds fixed-point constants, register indexes, the CORDIC arctangent table
// and the saturation helpers. No dependencies.
`default_nettype none

package ddio_pkg;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_MPP  = 3'd0;
  localparam logic [2:0] REG_IWB  = 3'd1;
  localparam logic [2:0] REG_INVL = 3'd2;
  localparam logic [2:0] REG_INVR = 3'd3;
  localparam logic [2:0] REG_SLIP = 3'd4;
  localparam logic [2:0] REG_MOVE = 3'd5;

  // Register reset values.
  localparam logic [31:0] MPP_RESET  = 32'd674664;
  localparam logic [23:0] IWB_RESET  = 24'd436907;
  localparam logic [23:0] SLIP_RESET = 24'd131072;
  localparam logic [23:0] MOVE_RESET = 24'd3277;

  // Angle constants in Q3.16 radians.
  localparam int PI_Q16      = 205887;
  localparam int TWO_PI_Q16  = 411775;
  localparam int HALF_PI_Q16 = 102944;

  // pi in Q32, and the centidegree to Q16 radian divisor (18000 * 65536).
  localparam logic [39:0] PI_Q32   = 40'd13493037705;
  localparam logic [30:0] YAW_DIV  = 31'd1179648000;
  localparam logic [63:0] YAW_HALF = 64'd589824000;

  // CORDIC starting gain in Q30.
  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

  // Yaw wrap limits in centidegrees.
  localparam int HALF_TURN_CD = 18000;
  localparam int FULL_TURN_CD = 36000;

  // Step time limits and the per-second scale.
  localparam logic [19:0] MAX_STEP_US = 20'd500000;
  localparam logic [31:0] US_PER_S    = 32'd1000000;

  // Arctangent of 2^-i in Q3.16 radians.
  function automatic logic [16:0] atan_q16(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30386;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // Saturate a sign and magnitude pair to a 32-bit signed value.
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (!neg) begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end else begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end
    return r;
  endfunction

  // Saturate a 36-bit signed sum to 32 bits.
  function automatic logic [31:0] sat_sum(input logic signed [35:0] v);
    logic [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/diff_drive_imu_odometry_core.sv
// Differential-drive odometry core: sequencer, shared bit-serial multiplier,
// bit-serial divider and iterative CORDIC, plus the APB register bank.
// Depends on ddio_pkg.
//
// Usage: an item on the input channel (in_valid / in_stall) carries opcode,
// two wrapping encoder counts, an IMU yaw and a step time. Each item yields
// exactly one result item on the output channel (out_valid / out_stall)
// holding the pose, speed, turn rate, slip flag and an updated flag.
// The block works on one item at a time; in_stall is high until the result
// of the current item has been taken.
// A reset opcode, an ignored step time or the first capture go straight to
// the result. A full update runs the yaw wrap steps, the CORDIC iterations,
// nine passes of the shared serial multiplier and four passes of the radix-2
// divider; the multiplier and divider passes dominate.
// When the receiver stalls, the result holds on the output ports and no new
// item is taken. Synchronous reset clears the pose state and loads the
// register defaults. Registers sit at byte address 4*index on the APB port.
`default_nettype none

module diff_drive_imu_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // Input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               opcode,
  input  wire logic signed [31:0] left_count,
  input  wire logic signed [31:0] right_count,
  input  wire logic signed [16:0] yaw_centideg,
  input  wire logic        [19:0] step_time_us,
  // Output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [18:0]      heading,
  output logic signed [31:0]      speed,
  output logic signed [31:0]      turn_rate,
  output logic                    slip,
  output logic                    updated,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [4:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  localparam int IW = $clog2(CORDIC_STEPS);

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DL   = 5'd1;
  localparam logic [4:0] S_DL2  = 5'd2;
  localparam logic [4:0] S_DR2  = 5'd3;
  localparam logic [4:0] S_TH   = 5'd4;
  localparam logic [4:0] S_WRAP = 5'd5;
  localparam logic [4:0] S_YR   = 5'd6;
  localparam logic [4:0] S_YR2  = 5'd7;
  localparam logic [4:0] S_SP   = 5'd8;
  localparam logic [4:0] S_SP2  = 5'd9;
  localparam logic [4:0] S_RT   = 5'd10;
  localparam logic [4:0] S_RT2  = 5'd11;
  localparam logic [4:0] S_CORD = 5'd12;
  localparam logic [4:0] S_CX   = 5'd13;
  localparam logic [4:0] S_X2   = 5'd14;
  localparam logic [4:0] S_Y2   = 5'd15;
  localparam logic [4:0] S_W    = 5'd16;
  localparam logic [4:0] S_W2   = 5'd17;
  localparam logic [4:0] S_MUL  = 5'd18;
  localparam logic [4:0] S_DIV  = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  // Configuration registers
  logic        [31:0] mpp;
  logic        [23:0] ibase;
  logic               inv_l;
  logic               inv_r;
  logic        [23:0] slip_lim;
  logic        [23:0] move_lim;

  // Persistent state
  logic        [31:0] prev_left;
  logic        [31:0] prev_right;
  logic               counts_captured;
  logic signed [16:0] yaw_reference;
  logic signed [18:0] last_heading;
  logic signed [31:0] x_acc;
  logic signed [31:0] y_acc;
  logic signed [18:0] heading_reg;
  logic signed [31:0] speed_reg;
  logic signed [31:0] rate_reg;
  logic               slip_reg;
  logic               upd;

  // Sequencer and latched item
  logic        [4:0]  state;
  logic        [4:0]  ret;
  logic        [5:0]  cnt;
  logic        [31:0] in_l;
  logic        [31:0] in_r;
  logic signed [16:0] in_yaw;
  logic        [19:0] in_dt;

  // Serial multiplier and divider
  logic        [71:0] prod;
  logic        [39:0] mul_a;
  logic               mneg;
  logic        [63:0] dnum;
  logic        [30:0] drem;
  logic        [30:0] dden;

  // Intermediate results
  logic signed [31:0] dl;
  logic               ds_neg;
  logic        [31:0] ds_mag;
  logic               te_neg;
  logic        [39:0] te_mag;
  logic signed [17:0] cd;
  logic signed [19:0] dth;

  // CORDIC
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic signed [20:0] ca;
  logic               cneg;
  logic        [IW-1:0] ci;

  // Combinational helpers
  logic signed [32:0] pl;
  logic signed [32:0] pr;
  logic signed [32:0] pl_s;
  logic signed [32:0] pr_s;
  logic        [31:0] pl_mag;
  logic        [31:0] pr_mag;
  logic        [63:0] rnd16;
  logic        [63:0] rnd30;
  logic        [31:0] dr_val;
  logic signed [32:0] sum_lr;
  logic        [32:0] sum_mag;
  logic        [33:0] sum_half;
  logic signed [32:0] diff_lr;
  logic        [32:0] diff_mag;
  logic        [17:0] cd_mag;
  logic signed [18:0] yr_v;
  logic signed [19:0] dth_raw;
  logic signed [19:0] dth_w;
  logic        [19:0] dth_mag;
  logic        [19:0] half_mag;
  logic signed [20:0] mid_raw;
  logic signed [20:0] mid_w;
  logic signed [20:0] a_init;
  logic               n_init;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [20:0] atan_v;
  logic signed [32:0] c_val;
  logic        [31:0] c_mag;
  logic signed [32:0] s_val;
  logic        [31:0] s_mag;
  logic signed [35:0] prod_term;
  logic        [31:0] x_next;
  logic        [31:0] y_next;
  logic signed [64:0] w_val;
  logic signed [65:0] err;
  logic        [65:0] err_mag;
  logic        [31:0] spd_mag;
  logic        [31:0] dtry;
  logic               dge;
  logic        [40:0] msum;
  logic               in_accept;
  logic               dt_ok;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && (state == S_IDLE);
  assign dt_ok     = (step_time_us != 20'd0) && (step_time_us <= ddio_pkg::MAX_STEP_US);
  assign out_valid = (state == S_OUT);
  assign pready    = 1'b1;

  assign pos_x     = x_acc;
  assign pos_y     = y_acc;
  assign heading   = heading_reg;
  assign speed     = speed_reg;
  assign turn_rate = rate_reg;
  assign slip      = slip_reg;
  assign updated   = upd;

  // Register read mux.
  always_comb begin
    unique case (paddr[4:2])
      ddio_pkg::REG_MPP:  prdata = mpp;
      ddio_pkg::REG_IWB:  prdata = {8'd0, ibase};
      ddio_pkg::REG_INVL: prdata = {31'd0, inv_l};
      ddio_pkg::REG_INVR: prdata = {31'd0, inv_r};
      ddio_pkg::REG_SLIP: prdata = {8'd0, slip_lim};
      ddio_pkg::REG_MOVE: prdata = {8'd0, move_lim};
      default:            prdata = 32'd0;
    endcase
  end

  // Datapath helpers feeding the sequencer.
  always_comb begin
    // Wheel pulse deltas with direction.
    pl      = $signed({in_l[31] ^ prev_left[31] ^ 1'b0, 32'(in_l - prev_left)});
    pl      = $signed({pl[31], pl[31:0]});
    pr      = $signed({1'b0, 32'(in_r - prev_right)});
    pr      = $signed({pr[31], pr[31:0]});
    pl_s    = inv_l ? -pl : pl;
    pr_s    = inv_r ? -pr : pr;
    pl_mag  = 32'(pl_s[32] ? -pl_s : pl_s);
    pr_mag  = 32'(pr_s[32] ? -pr_s : pr_s);

    // Rounded product shifts.
    rnd16   = prod[63:0] + 64'h8000;
    rnd30   = prod[63:0] + 64'h2000_0000;

    // Right wheel distance, distance mean and difference.
    dr_val   = ddio_pkg::sat_mag(mneg, {16'd0, rnd16[63:16]});
    sum_lr   = $signed({dl[31], dl}) + $signed({dr_val[31], dr_val});
    sum_mag  = 33'(sum_lr[32] ? -sum_lr : sum_lr);
    sum_half = {1'b0, sum_mag} + 34'd1;
    diff_lr  = $signed({dr_val[31], dr_val}) - $signed({dl[31], dl});
    diff_mag = 33'(diff_lr[32] ? -diff_lr : diff_lr);

    cd_mag  = 18'(cd[17] ? -cd : cd);

    // Heading and its change, wrapped by one turn.
    yr_v    = mneg ? -$signed(19'(dnum)) : $signed(19'(dnum));
    dth_raw = $signed({yr_v[18], yr_v}) - $signed({last_heading[18], last_heading});
    dth_w   = dth_raw;
    if (dth_w > 20'(ddio_pkg::PI_Q16)) begin
      dth_w = dth_w - 20'(ddio_pkg::TWO_PI_Q16);
    end
    if (dth_w < -20'(ddio_pkg::PI_Q16)) begin
      dth_w = dth_w + 20'(ddio_pkg::TWO_PI_Q16);
    end
    dth_mag = 20'(dth[19] ? -dth : dth);

    // Mid-point heading.
    half_mag = 20'(({1'b0, dth_mag} + 21'd1) >> 1);
    mid_raw  = $signed({{2{heading_reg[18]}}, heading_reg})
             - (dth[19] ? -$signed({1'b0, half_mag}) : $signed({1'b0, half_mag}));
    mid_w    = mid_raw;
    if (mid_w > 21'(ddio_pkg::PI_Q16)) begin
      mid_w = mid_w - 21'(ddio_pkg::TWO_PI_Q16);
    end
    if (mid_w < -21'(ddio_pkg::PI_Q16)) begin
      mid_w = mid_w + 21'(ddio_pkg::TWO_PI_Q16);
    end

    // CORDIC range reduction into the right half plane.
    a_init = mid_w;
    n_init = 1'b0;
    if (mid_w > 21'(ddio_pkg::HALF_PI_Q16)) begin
      a_init = mid_w - 21'(ddio_pkg::PI_Q16);
      n_init = 1'b1;
    end else if (mid_w < -21'(ddio_pkg::HALF_PI_Q16)) begin
      a_init = mid_w + 21'(ddio_pkg::PI_Q16);
      n_init = 1'b1;
    end

    // One CORDIC rotation.
    xs     = cx >>> ci;
    ys     = cy >>> ci;
    atan_v = $signed({4'd0, ddio_pkg::atan_q16(5'(ci))});

    c_val  = cneg ? -cx : cx;
    c_mag  = 32'(c_val[32] ? -c_val : c_val);
    s_val  = cneg ? -cy : cy;
    s_mag  = 32'(s_val[32] ? -s_val : s_val);

    // Position step and accumulation.
    prod_term = mneg ? -$signed({2'b0, rnd30[63:30]}) : $signed({2'b0, rnd30[63:30]});
    x_next    = ddio_pkg::sat_sum($signed({{4{x_acc[31]}}, x_acc}) + prod_term);
    y_next    = ddio_pkg::sat_sum($signed({{4{y_acc[31]}}, y_acc}) + prod_term);

    // Encoder turn rate against the IMU turn rate.
    w_val   = te_neg ? -$signed({1'b0, dnum}) : $signed({1'b0, dnum});
    err     = $signed({w_val[64], w_val}) - $signed({{34{rate_reg[31]}}, rate_reg});
    err_mag = 66'(err[65] ? -err : err);
    spd_mag = 32'(speed_reg[31] ? -speed_reg : speed_reg);

    // Divider and multiplier steps.
    dtry = {drem, dnum[63]};
    dge  = (dtry >= {1'b0, dden});
    msum = {1'b0, prod[71:32]} + (prod[0] ? {1'b0, mul_a} : 41'd0);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mpp      <= ddio_pkg::MPP_RESET;
      ibase    <= ddio_pkg::IWB_RESET;
      inv_l    <= 1'b0;
      inv_r    <= 1'b0;
      slip_lim <= ddio_pkg::SLIP_RESET;
      move_lim <= ddio_pkg::MOVE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        ddio_pkg::REG_MPP:  mpp      <= pwdata;
        ddio_pkg::REG_IWB:  ibase    <= pwdata[23:0];
        ddio_pkg::REG_INVL: inv_l    <= pwdata[0];
        ddio_pkg::REG_INVR: inv_r    <= pwdata[0];
        ddio_pkg::REG_SLIP: slip_lim <= pwdata[23:0];
        ddio_pkg::REG_MOVE: move_lim <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ret             <= S_IDLE;
      cnt             <= 6'd0;
      prev_left       <= 32'd0;
      prev_right      <= 32'd0;
      counts_captured <= 1'b0;
      yaw_reference   <= 17'sd0;
      last_heading    <= 19'sd0;
      x_acc           <= 32'sd0;
      y_acc           <= 32'sd0;
      heading_reg     <= 19'sd0;
      speed_reg       <= 32'sd0;
      rate_reg        <= 32'sd0;
      slip_reg        <= 1'b0;
      upd             <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            in_l   <= left_count;
            in_r   <= right_count;
            in_yaw <= yaw_centideg;
            in_dt  <= step_time_us;
            if (opcode) begin
              x_acc           <= 32'sd0;
              y_acc           <= 32'sd0;
              heading_reg     <= 19'sd0;
              speed_reg       <= 32'sd0;
              rate_reg        <= 32'sd0;
              slip_reg        <= 1'b0;
              yaw_reference   <= yaw_centideg;
              last_heading    <= 19'sd0;
              prev_left       <= 32'd0;
              prev_right      <= 32'd0;
              counts_captured <= 1'b0;
              upd             <= 1'b1;
              state           <= S_OUT;
            end else if (!dt_ok) begin
              upd   <= 1'b0;
              state <= S_OUT;
            end else if (!counts_captured) begin
              prev_left       <= left_count;
              prev_right      <= right_count;
              counts_captured <= 1'b1;
              yaw_reference   <= yaw_centideg;
              last_heading    <= 19'sd0;
              upd             <= 1'b0;
              state           <= S_OUT;
            end else begin
              state <= S_DL;
            end
          end
        end
        // Left wheel distance.
        S_DL: begin
          mul_a <= {8'd0, mpp};
          prod  <= {40'd0, pl_mag};
          mneg  <= pl_s[32];
          cnt   <= 6'd0;
          ret   <= S_DL2;
          state <= S_MUL;
        end
        S_DL2: begin
          dl    <= ddio_pkg::sat_mag(mneg, {16'd0, rnd16[63:16]});
          mul_a <= {8'd0, mpp};
          prod  <= {40'd0, pr_mag};
          mneg  <= pr_s[32];
          cnt   <= 6'd0;
          ret   <= S_DR2;
          state <= S_MUL;
        end
        // Distance mean and encoder heading change.
        S_DR2: begin
          ds_neg     <= sum_lr[32];
          ds_mag     <= sum_half[32:1];
          prev_left  <= in_l;
          prev_right <= in_r;
          mul_a      <= 40'(diff_mag);
          prod       <= {48'd0, ibase};
          mneg       <= diff_lr[32];
          cnt        <= 6'd0;
          ret        <= S_TH;
          state      <= S_MUL;
        end
        S_TH: begin
          te_neg <= mneg;
          te_mag <= rnd16[55:16];
          cd     <= $signed({in_yaw[16], in_yaw}) - $signed({yaw_reference[16], yaw_reference});
          state  <= S_WRAP;
        end
        // Wrap the yaw difference by whole turns.
        S_WRAP: begin
          if (cd > 18'(ddio_pkg::HALF_TURN_CD)) begin
            cd <= cd - 18'(ddio_pkg::FULL_TURN_CD);
          end else if (cd < -18'(ddio_pkg::HALF_TURN_CD)) begin
            cd <= cd + 18'(ddio_pkg::FULL_TURN_CD);
          end else begin
            mul_a <= ddio_pkg::PI_Q32;
            prod  <= {54'd0, cd_mag};
            mneg  <= cd[17];
            cnt   <= 6'd0;
            ret   <= S_YR;
            state <= S_MUL;
          end
        end
        S_YR: begin
          dnum  <= prod[63:0] + ddio_pkg::YAW_HALF;
          dden  <= ddio_pkg::YAW_DIV;
          drem  <= 31'd0;
          cnt   <= 6'd0;
          ret   <= S_YR2;
          state <= S_DIV;
        end
        // Heading, heading change, then speed.
        S_YR2: begin
          heading_reg  <= yr_v;
          last_heading <= yr_v;
          dth          <= dth_w;
          mul_a        <= {8'd0, ds_mag};
          prod         <= {40'd0, ddio_pkg::US_PER_S};
          cnt          <= 6'd0;
          ret          <= S_SP;
          state        <= S_MUL;
        end
        S_SP: begin
          dnum  <= prod[63:0] + {45'd0, in_dt[19:1]};
          dden  <= {11'd0, in_dt};
          drem  <= 31'd0;
          cnt   <= 6'd0;
          ret   <= S_SP2;
          state <= S_DIV;
        end
        S_SP2: begin
          speed_reg <= ddio_pkg::sat_mag(ds_neg, dnum);
          mul_a     <= {20'd0, dth_mag};
          prod      <= {40'd0, ddio_pkg::US_PER_S};
          cnt       <= 6'd0;
          ret       <= S_RT;
          state     <= S_MUL;
        end
        S_RT: begin
          dnum  <= prod[63:0] + {45'd0, in_dt[19:1]};
          dden  <= {11'd0, in_dt};
          drem  <= 31'd0;
          cnt   <= 6'd0;
          ret   <= S_RT2;
          state <= S_DIV;
        end
        // Turn rate, then start the CORDIC on the mid-point heading.
        S_RT2: begin
          rate_reg <= ddio_pkg::sat_mag(dth[19], dnum);
          cx       <= ddio_pkg::GAIN_Q30;
          cy       <= 33'sd0;
          ca       <= a_init;
          cneg     <= n_init;
          ci       <= '0;
          state    <= S_CORD;
        end
        S_CORD: begin
          if (ca >= 21'sd0) begin
            cx <= cx - ys;
            cy <= cy + xs;
            ca <= ca - atan_v;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            ca <= ca + atan_v;
          end
          ci <= ci + 1'b1;
          if (ci == IW'(CORDIC_STEPS - 1)) begin
            state <= S_CX;
          end
        end
        // Position steps along x and y.
        S_CX: begin
          mul_a <= {8'd0, ds_mag};
          prod  <= {40'd0, c_mag};
          mneg  <= ds_neg ^ c_val[32];
          cnt   <= 6'd0;
          ret   <= S_X2;
          state <= S_MUL;
        end
        S_X2: begin
          x_acc <= x_next;
          mul_a <= {8'd0, ds_mag};
          prod  <= {40'd0, s_mag};
          mneg  <= ds_neg ^ s_val[32];
          cnt   <= 6'd0;
          ret   <= S_Y2;
          state <= S_MUL;
        end
        S_Y2: begin
          y_acc <= y_next;
          mul_a <= te_mag;
          prod  <= {40'd0, ddio_pkg::US_PER_S};
          cnt   <= 6'd0;
          ret   <= S_W;
          state <= S_MUL;
        end
        S_W: begin
          dnum  <= prod[63:0] + {45'd0, in_dt[19:1]};
          dden  <= {11'd0, in_dt};
          drem  <= 31'd0;
          cnt   <= 6'd0;
          ret   <= S_W2;
          state <= S_DIV;
        end
        // Slip decision.
        S_W2: begin
          slip_reg <= (err_mag > {42'd0, slip_lim}) && (spd_mag > {8'd0, move_lim});
          upd      <= 1'b1;
          state    <= S_OUT;
        end
        // Shift-and-add multiply, one multiplier bit per cycle.
        S_MUL: begin
          prod <= {msum, prod[31:1]};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= ret;
          end
        end
        // Restoring divide, one quotient bit per cycle.
        S_DIV: begin
          drem <= dge ? 31'(dtry - {1'b0, dden}) : dtry[30:0];
          dnum <= {dnum[62:0], dge};
          cnt  <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            state <= ret;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
